>>> sv/button_debounce_hold_detector_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce and hold detector
// Each macro wraps one concurrent assertion and reports through $error.
// Defining ASSERT_OFF turns every check into an empty statement.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_HOLD_DETECTOR_DEFINES_SVH
`define BUTTON_DEBOUNCE_HOLD_DETECTOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked at every edge outside reset.
`define BDH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define BDH_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BDH_ASSERT(label, clk, rst_n, prop, msg)
`define BDH_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> sv/bdh_pkg.sv
// ----------------------------------------------------------------------------
// bdh_pkg
// Types and constants shared by the button debounce and hold detector.
// ----------------------------------------------------------------------------
package bdh_pkg;

    localparam int NUM_BUTTONS_DEF = 5;
    localparam int COUNT_WIDTH_DEF = 16;

    // Width of the pin field and of each event field.
    localparam int PIN_W     = 5;
    localparam int DELAY_W   = 16;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    localparam logic [DELAY_W-1:0] DEBOUNCE_DELAY_RST = 16'd50;
    localparam logic [DELAY_W-1:0] HOLD_DELAY_RST     = 16'd1000;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_DELAY = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_DELAY     = 1'b1;

    typedef enum logic [2:0] {
        ST_RELEASED = 3'd0,
        ST_DEBOUNCE = 3'd1,
        ST_LOCKED   = 3'd2,
        ST_HOLD     = 3'd3,
        ST_PRESSED  = 3'd4
    } t_btn_state;

    // Events that one button raises on one tick.
    typedef struct packed {
        logic press;
        logic hold;
        logic hold_end;
    } t_lane_evt;

endpackage

>>> sv/bdh_lane.sv
// ----------------------------------------------------------------------------
// bdh_lane
// Debounce and hold state machine with a saturating tick counter for one
// button. State moves only on ticks that the stream accepts.
// ----------------------------------------------------------------------------
`include "button_debounce_hold_detector_defines.svh"

module bdh_lane #(
    parameter int COUNT_WIDTH = bdh_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  logic                         i_level,
    input  logic [bdh_pkg::DELAY_W-1:0]  i_debounce_delay,
    input  logic [bdh_pkg::DELAY_W-1:0]  i_hold_delay,
    output bdh_pkg::t_lane_evt           o_evt
);

    localparam int CMP_W = (COUNT_WIDTH > bdh_pkg::DELAY_W) ? COUNT_WIDTH : bdh_pkg::DELAY_W;

    bdh_pkg::t_btn_state      r_state, n_state;
    logic [COUNT_WIDTH-1:0]   r_cnt, n_cnt;
    logic                     r_prev_level;
    logic [COUNT_WIDTH-1:0]   cnt_inc;
    logic                     past_debounce;
    logic                     past_hold;

    // The counter stops at all ones, so a delay of all ones is never passed.
    assign cnt_inc       = (&r_cnt) ? r_cnt : r_cnt + 1'b1;
    assign past_debounce = CMP_W'(cnt_inc) > CMP_W'(i_debounce_delay);
    assign past_hold     = CMP_W'(cnt_inc) > CMP_W'(i_hold_delay);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bdh_pkg::ST_RELEASED;
            r_cnt        <= '0;
            r_prev_level <= 1'b0;
        end else if (i_advance) begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_prev_level <= i_level;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_evt   = '0;
        case (r_state)
            bdh_pkg::ST_DEBOUNCE: begin
                n_cnt = cnt_inc;
                if (past_debounce) begin
                    n_state = i_level ? bdh_pkg::ST_LOCKED : bdh_pkg::ST_RELEASED;
                end
            end
            bdh_pkg::ST_LOCKED: begin
                n_cnt = cnt_inc;
                if (!i_level) begin
                    n_state = bdh_pkg::ST_PRESSED;
                end else if (past_hold) begin
                    n_state = bdh_pkg::ST_HOLD;
                end
            end
            bdh_pkg::ST_HOLD: begin
                n_cnt = cnt_inc;
                if (i_level) begin
                    o_evt.hold = 1'b1;
                end else begin
                    o_evt.hold_end = 1'b1;
                    n_state        = bdh_pkg::ST_RELEASED;
                end
            end
            bdh_pkg::ST_PRESSED: begin
                o_evt.press = 1'b1;
                n_state     = bdh_pkg::ST_RELEASED;
            end
            default: begin
                // Only a rising edge seen while released starts a new press.
                if (i_level && !r_prev_level) begin
                    n_state = bdh_pkg::ST_DEBOUNCE;
                    n_cnt   = '0;
                end
            end
        endcase
    end

    `BDH_ASSERT(a_evt_onehot0, i_clk, i_rst_n, $onehot0(o_evt), "lane raised two events at once")
    `BDH_ASSERT(a_hold_stays, i_clk, i_rst_n,
        i_advance && r_state == bdh_pkg::ST_HOLD && i_level |=> r_state == bdh_pkg::ST_HOLD,
        "held button left hold while still high")
    `BDH_ASSERT(a_press_returns, i_clk, i_rst_n,
        i_advance && o_evt.press |=> r_state == bdh_pkg::ST_RELEASED,
        "press event not followed by release state")

endmodule

>>> sv/bdh_merge.sv
// ----------------------------------------------------------------------------
// bdh_merge
// Gathers the events of all lanes into one result word and holds it in an
// output register backed by a skid register.
// ----------------------------------------------------------------------------
`include "button_debounce_hold_detector_defines.svh"

module bdh_merge #(
    parameter int NUM_BUTTONS = bdh_pkg::NUM_BUTTONS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  bdh_pkg::t_lane_evt [NUM_BUTTONS-1:0] i_evt,
    output logic                            o_ready,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [bdh_pkg::M_TDATA_W-1:0]   o_tdata
);

    localparam int PW = bdh_pkg::PIN_W;

    logic [PW-1:0]                   press_bits, hold_bits, hold_end_bits;
    logic [bdh_pkg::M_TDATA_W-1:0]   n_data;
    logic [bdh_pkg::M_TDATA_W-1:0]   r_out_data, r_skid_data;
    logic                            r_out_valid, r_skid_valid;
    logic                            pop;

    // Only the buttons that the pin field covers report events.
    for (genvar g = 0; g < PW; g++) begin : g_bits
        if (g < NUM_BUTTONS) begin : g_lane
            assign press_bits[g]    = i_evt[g].press;
            assign hold_bits[g]     = i_evt[g].hold;
            assign hold_end_bits[g] = i_evt[g].hold_end;
        end else begin : g_none
            assign press_bits[g]    = 1'b0;
            assign hold_bits[g]     = 1'b0;
            assign hold_end_bits[g] = 1'b0;
        end
    end

    assign n_data   = bdh_pkg::M_TDATA_W'({hold_end_bits, hold_bits, press_bits});
    assign pop      = r_out_valid && i_tready;
    assign o_ready  = !r_skid_valid;
    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                if (!r_out_valid || pop) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (pop) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (!r_out_valid || pop) begin
                r_out_data <= n_data;
            end else begin
                r_skid_data <= n_data;
            end
        end else if (pop && r_skid_valid) begin
            r_out_data <= r_skid_data;
        end
    end

    `BDH_ASSERT(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid,
        "skid register full while output register empty")
    `BDH_ASSERT(a_stall_fills_skid, i_clk, i_rst_n,
        i_accept && r_out_valid && !i_tready |=> r_skid_valid,
        "stalled result not parked in skid register")
    `BDH_ASSERT(a_drain_empties, i_clk, i_rst_n,
        pop && !i_accept && !r_skid_valid |=> !r_out_valid,
        "output stayed valid after its only transaction left")

endmodule

>>> sv/button_debounce_hold_detector.sv
// ----------------------------------------------------------------------------
// button_debounce_hold_detector
// Per-button debounce, short press and long press detection on a tick stream.
// ----------------------------------------------------------------------------
// Each input transaction is one tick: tdata[4:0] holds the sampled level of
// every button. Each tick yields exactly one output transaction with the
// press, hold and hold-end event bits of that tick.
// Every button has its own lane with a state machine and a saturating tick
// counter; all lanes step together on an accepted tick and the merge stage
// packs their events. Results are registered in the output register, and one
// tick per cycle is sustained while the receiver keeps tready high.
// An output register plus a skid register sit on the output side: when the
// receiver stalls, one more tick is taken into the skid register and then
// s_axis tready drops until the receiver drains it.
// Reset (synchronous, active low) puts every button in the released state,
// clears the counters and the previous levels, empties the output side and
// loads the delays with 50 and 1000 ticks. Write the delays through the
// configuration port only while no tick is in flight.
// ----------------------------------------------------------------------------
module button_debounce_hold_detector #(
    parameter int NUM_BUTTONS = bdh_pkg::NUM_BUTTONS_DEF,
    parameter int COUNT_WIDTH = bdh_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [4:0] pin_levels, [7:5] zero
    input  logic [bdh_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [4:0] press_events, [9:5] hold_events, [14:10] hold_end_events, [15] zero
    output logic [bdh_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [bdh_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [bdh_pkg::DELAY_W-1:0]       i_cfg_wdata
);

    logic [bdh_pkg::DELAY_W-1:0]        r_debounce_delay, r_hold_delay;
    logic                               accept;
    logic [NUM_BUTTONS-1:0]             levels;
    bdh_pkg::t_lane_evt [NUM_BUTTONS-1:0] lane_evt;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_delay <= bdh_pkg::DEBOUNCE_DELAY_RST;
            r_hold_delay     <= bdh_pkg::HOLD_DELAY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bdh_pkg::CFG_DEBOUNCE_DELAY: r_debounce_delay <= i_cfg_wdata;
                bdh_pkg::CFG_HOLD_DELAY:     r_hold_delay     <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Buttons beyond the pin field always see a low level.
    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lanes
        if (g < bdh_pkg::PIN_W) begin : g_pin
            assign levels[g] = i_s_axis_tdata[g];
        end else begin : g_low
            assign levels[g] = 1'b0;
        end

        bdh_lane #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_lane (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_advance        (accept),
            .i_level          (levels[g]),
            .i_debounce_delay (r_debounce_delay),
            .i_hold_delay     (r_hold_delay),
            .o_evt            (lane_evt[g])
        );
    end

    bdh_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_evt    (lane_evt),
        .o_ready  (o_s_axis_tready),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata)
    );

endmodule

>>> tb/button_debounce_hold_detector_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_debounce_hold_detector_tb
// Sends tick transactions through the detector and checks every result
// against a cycle-free behavioral model of the five button state machines.
// The run covers the reset debounce delay, a short directed sequence and
// random press patterns under several delay settings, both delay extremes
// included, with random stalls on both stream sides.
// ----------------------------------------------------------------------------
module button_debounce_hold_detector_tb;

    localparam int NB          = bdh_pkg::PIN_W;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_TICKS = 100;

    typedef struct packed {
        logic [NB-1:0] press;
        logic [NB-1:0] hold;
        logic [NB-1:0] hold_end;
    } t_tick_events;

    logic                            i_clk           = 1'b0;
    logic                            i_rst_n         = 1'b0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [bdh_pkg::S_TDATA_W-1:0]   i_s_axis_tdata  = '0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    logic [bdh_pkg::M_TDATA_W-1:0]   o_m_axis_tdata;
    logic                            i_cfg_we        = 1'b0;
    logic [bdh_pkg::CFG_INDEX_W-1:0] i_cfg_index     = bdh_pkg::CFG_DEBOUNCE_DELAY;
    logic [bdh_pkg::DELAY_W-1:0]     i_cfg_wdata     = '0;

    // Behavioral copy of the button lanes and the delay registers.
    bdh_pkg::t_btn_state         btn_phase [NB];
    logic [bdh_pkg::DELAY_W-1:0] btn_ticks [NB];
    logic [NB-1:0]               btn_prev;
    logic [bdh_pkg::DELAY_W-1:0] cur_debounce;
    logic [bdh_pkg::DELAY_W-1:0] cur_hold;

    t_tick_events pending_events[$];

    // Random press pattern generator state.
    int            run_left [NB];
    logic [NB-1:0] lv_held = '0;

    bit stalls_on = 1'b1;
    int stall_left = 0;
    int errors = 0;
    int cycle_count = 0;
    int ticks_sent = 0;
    int settings_used = 0;
    int press_seen = 0;
    int hold_seen = 0;
    int hold_end_seen = 0;

    button_debounce_hold_detector u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_events.size());
            $display("** button_debounce_hold_detector: FAILED **");
            $finish;
        end
    end

    function automatic void reset_buttons();
        for (int b = 0; b < NB; b++) begin
            btn_phase[b] = bdh_pkg::ST_RELEASED;
            btn_ticks[b] = '0;
            run_left[b]  = 0;
        end
        btn_prev     = '0;
        cur_debounce = bdh_pkg::DEBOUNCE_DELAY_RST;
        cur_hold     = bdh_pkg::HOLD_DELAY_RST;
    endfunction

    // Advances every button by one tick and returns the events it raises.
    function automatic t_tick_events step_buttons(input logic [NB-1:0] lv);
        t_tick_events                ev;
        logic [bdh_pkg::DELAY_W-1:0] cnt;
        ev = '0;
        for (int b = 0; b < NB; b++) begin
            cnt = (btn_ticks[b] == '1) ? btn_ticks[b] : btn_ticks[b] + 1'b1;
            case (btn_phase[b])
                bdh_pkg::ST_DEBOUNCE: begin
                    btn_ticks[b] = cnt;
                    if (cnt > cur_debounce) begin
                        if (lv[b])
                            btn_phase[b] = bdh_pkg::ST_LOCKED;
                        else
                            btn_phase[b] = bdh_pkg::ST_RELEASED;
                    end
                end
                bdh_pkg::ST_LOCKED: begin
                    btn_ticks[b] = cnt;
                    if (!lv[b])
                        btn_phase[b] = bdh_pkg::ST_PRESSED;
                    else if (cnt > cur_hold)
                        btn_phase[b] = bdh_pkg::ST_HOLD;
                end
                bdh_pkg::ST_HOLD: begin
                    btn_ticks[b] = cnt;
                    if (lv[b]) begin
                        ev.hold[b] = 1'b1;
                    end else begin
                        ev.hold_end[b] = 1'b1;
                        btn_phase[b]   = bdh_pkg::ST_RELEASED;
                    end
                end
                bdh_pkg::ST_PRESSED: begin
                    ev.press[b]  = 1'b1;
                    btn_phase[b] = bdh_pkg::ST_RELEASED;
                end
                default: begin
                    // Only a released button reacts to a rising edge.
                    if (lv[b] && !btn_prev[b]) begin
                        btn_phase[b] = bdh_pkg::ST_DEBOUNCE;
                        btn_ticks[b] = '0;
                    end
                end
            endcase
            btn_prev[b] = lv[b];
        end
        return ev;
    endfunction

    // Each button holds its level for a random run, scaled to the current
    // delays and capped at 40, so that small delays reach debounce, lock and hold;
    // single-tick glitches are mixed in as noise.
    function automatic logic [NB-1:0] draw_levels();
        int            span;
        logic [NB-1:0] lv;
        span = int'(cur_debounce) + int'(cur_hold) + 4;
        if (span > 40)
            span = 40;
        for (int b = 0; b < NB; b++) begin
            if (run_left[b] == 0) begin
                lv_held[b]  = !lv_held[b];
                run_left[b] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                          : $urandom_range(1, span);
            end
            run_left[b]--;
        end
        lv = lv_held;
        if ($urandom_range(0, 15) == 0)
            lv[$urandom_range(0, NB - 1)] ^= 1'b1;
        return lv;
    endfunction

    task automatic send_tick(input logic [NB-1:0] lv);
        int gap;
        if (stalls_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= bdh_pkg::S_TDATA_W'(lv);
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_events.push_back(step_buttons(lv));
        ticks_sent++;
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic load_delays(input logic [bdh_pkg::DELAY_W-1:0] debounce,
                               input logic [bdh_pkg::DELAY_W-1:0] hold);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= bdh_pkg::CFG_DEBOUNCE_DELAY;
        i_cfg_wdata <= debounce;
        @(posedge i_clk);
        i_cfg_index <= bdh_pkg::CFG_HOLD_DELAY;
        i_cfg_wdata <= hold;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        cur_debounce = debounce;
        cur_hold     = hold;
        settings_used++;
    endtask

    task automatic report_field(input string name, input logic [NB-1:0] exp_v,
                                input logic [NB-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %b actual %b", $time, name, exp_v,
                     act_v);
            errors++;
        end
    endtask

    // Receiver: random stall bursts and checking of every result transaction.
    always @(posedge i_clk) begin
        t_tick_events exp_ev;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time,
                         o_m_axis_tdata);
                errors++;
            end else begin
                exp_ev = pending_events.pop_front();
                report_field("press_events", exp_ev.press, o_m_axis_tdata[NB-1:0]);
                report_field("hold_events", exp_ev.hold, o_m_axis_tdata[2*NB-1:NB]);
                report_field("hold_end_events", exp_ev.hold_end,
                             o_m_axis_tdata[3*NB-1:2*NB]);
            end
            press_seen    += $countones(o_m_axis_tdata[NB-1:0]);
            hold_seen     += $countones(o_m_axis_tdata[2*NB-1:NB]);
            hold_end_seen += $countones(o_m_axis_tdata[3*NB-1:2*NB]);
        end
        if (stall_left > 0)
            stall_left--;
        else if (stalls_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 8);
        i_m_axis_tready <= (stall_left == 0);
    end

    // Default debounce delay of 50 ticks, probed right at its boundary; the
    // long presses lock and release well before the default hold delay.
    task automatic test_reset_delays();
        logic [NB-1:0] lv;
        for (int t = 0; t < 260; t++) begin
            lv[0] = (t < 200);
            lv[1] = (t < 53);
            lv[2] = (t >= 100 && t < 151);
            lv[3] = (t >= 200 && t < 252);
            lv[4] = (t % 7 == 0);
            send_tick(lv);
        end
    endtask

    // Glitches, short presses, long presses, a rising level on the tick a
    // press returns to released, and all-zero and all-one ticks.
    task automatic test_directed();
        logic [NB-1:0] seq [24];
        seq = '{5'h00, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1E, 5'h1F, 5'h1F,
                5'h1F, 5'h1F, 5'h0F, 5'h0E, 5'h00, 5'h04, 5'h00, 5'h00,
                5'h00, 5'h15, 5'h15, 5'h15, 5'h0A, 5'h15, 5'h15, 5'h00};
        load_delays(16'd2, 16'd5);
        foreach (seq[k])
            send_tick(seq[k]);
    endtask

    task automatic test_random_presses();
        logic [bdh_pkg::DELAY_W-1:0] db_set [7];
        logic [bdh_pkg::DELAY_W-1:0] hd_set [7];
        db_set = '{16'd0, 16'd1, 16'd3, 16'hFFFF, 16'd2, 16'd0, 16'd4};
        hd_set = '{16'd0, 16'd3, 16'd12, 16'd0, 16'd6, 16'hFFFF, 16'd20};
        foreach (db_set[p]) begin
            // The final setting runs with both sides streaming at full rate.
            if (p == 6)
                stalls_on = 1'b0;
            load_delays(db_set[p], hd_set[p]);
            for (int t = 0; t < PHASE_TICKS; t++) begin
                if (p == 2 && t == PHASE_TICKS / 2)
                    wait_drained();
                send_tick(draw_levels());
            end
        end
    endtask

    initial begin
        reset_buttons();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_delays();
        test_directed();
        test_random_presses();

        wait_drained();
        repeat (4) @(posedge i_clk);
        $display("Checked %0d ticks over %0d delay settings plus the reset delays.",
                 ticks_sent, settings_used);
        $display("Events observed: %0d press, %0d hold, %0d hold-end.", press_seen,
                 hold_seen, hold_end_seen);
        if (errors == 0) begin
            $display("** button_debounce_hold_detector: PASSED **");
        end else begin
            $display("** button_debounce_hold_detector: FAILED **");
        end
        $finish;
    end

endmodule
